@@ rtl/vbm_pkg.sv @@
// ----------------------------------------------------------------------------
// vbm_pkg
// Shared types and constants of the voxel boundary marker.
// ----------------------------------------------------------------------------
package vbm_pkg;

    localparam int GRID_SIZE = 32;
    localparam int ROW_W = 32;
    localparam int EDGE = (GRID_SIZE < ROW_W) ? GRID_SIZE : ROW_W;
    localparam int IDX_W = 5;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(25);
    localparam logic [ROW_W-1:0] ROW_MASK =
        (EDGE >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((64'd1 << EDGE) - 64'd1);
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic [IDX_W-1:0] EDGE_LAST = IDX_W'(EDGE - 1);
    localparam logic [1:0] ADDR_THRESHOLD = 2'd0;

    typedef struct packed {
        logic              is_read;
        logic              in_grid;
        logic [IDX_W-1:0]  plane;
        logic [IDX_W-1:0]  row;
        logic [ROW_W-1:0]  bits;
    } vbm_cmd_t;

endpackage

@@ rtl/vbm_front.sv @@
// ----------------------------------------------------------------------------
// vbm_front
// Accepts request words, checks range, and queues them for the back end.
// ----------------------------------------------------------------------------
module vbm_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [vbm_pkg::IDX_W-1:0] s_plane_index,
    input  logic [vbm_pkg::IDX_W-1:0] s_row_index,
    input  logic [vbm_pkg::ROW_W-1:0] s_row_bits,
    output logic                      q_valid,
    input  logic                      q_ready,
    output vbm_pkg::vbm_cmd_t         q_cmd
);
    import vbm_pkg::*;

    vbm_cmd_t    slot_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    vbm_cmd_t    cmd;
    logic        push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = slot_reg[rp_reg];

    always_comb begin
        cmd.is_read = (s_req_type == REQ_READ);
        cmd.in_grid = (s_plane_index <= EDGE_LAST) && (s_row_index <= EDGE_LAST);
        cmd.plane = s_plane_index;
        cmd.row = s_row_index;
        cmd.bits = s_row_bits & ROW_MASK;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
        if (push) slot_reg[wp_reg] <= cmd;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |=> (cnt_reg != 2'd2)) else $error("queue jumped");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_ready) else $error("full queue accepts");
`endif
endmodule

@@ rtl/vbm_back.sv @@
// ----------------------------------------------------------------------------
// vbm_back
// Row memory and neighborhood counter: writes rows, and for a read walks the
// nine neighbor rows one per cycle, accumulating per-voxel counts.
// ----------------------------------------------------------------------------
module vbm_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  vbm_pkg::vbm_cmd_t         q_cmd,
    input  logic [vbm_pkg::CNT_W-1:0] thresh,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [vbm_pkg::ROW_W-1:0] m_in_range_bits,
    output logic [vbm_pkg::ROW_W-1:0] m_drawable_bits
);
    import vbm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [ROW_W-1:0] mem [1 << ADDR_W];
    logic [ROW_W-1:0] rd_reg;
    logic [1:0]       st_reg, st_next;
    logic [3:0]       step_reg;
    logic             used_reg;
    logic             self_reg;
    logic [IDX_W-1:0] plane_reg, row_reg;
    logic [4:0]       cnt_reg [ROW_W];
    logic [ROW_W-1:0] self_bits_reg;
    logic             out_valid_reg, out_valid_next;
    logic [ROW_W-1:0] out_in_reg, out_dr_reg;
    logic [1:0]       dp, dr;
    logic [IDX_W:0]   np, nr;
    logic             nvalid;
    logic             take;
    logic [ROW_W-1:0] row_m;
    logic [ROW_W-1:0] drw;

    assign m_valid = out_valid_reg;
    assign m_in_range_bits = out_in_reg;
    assign m_drawable_bits = out_dr_reg;
    assign q_ready = (st_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign take = q_valid && q_ready;

    always_comb begin
        dp = step_reg < 4'd3 ? 2'd0 : (step_reg < 4'd6 ? 2'd1 : 2'd2);
        dr = 2'(step_reg - {2'd0, dp} * 4'd3);
        np = {1'b0, plane_reg} + {4'd0, dp} - 6'd1;
        nr = {1'b0, row_reg} + {4'd0, dr} - 6'd1;
        nvalid = !np[IDX_W] && !nr[IDX_W] && (np[IDX_W-1:0] <= EDGE_LAST)
            && (nr[IDX_W-1:0] <= EDGE_LAST);
        row_m = rd_reg & ROW_MASK;
        for (int k = 0; k < ROW_W; k++) begin
            drw[k] = self_bits_reg[k] && (cnt_reg[k] <= thresh);
        end
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (take && q_cmd.is_read && q_cmd.in_grid) st_next = ST_SCAN;
            ST_SCAN: if (step_reg == 4'd8) st_next = ST_DRAIN;
            ST_DRAIN: st_next = ST_LAST;
            ST_LAST: if (!out_valid_reg || m_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        out_valid_next = out_valid_reg && !m_ready;
        if (take && q_cmd.is_read && !q_cmd.in_grid) out_valid_next = 1'b1;
        if (st_reg == ST_LAST && (!out_valid_reg || m_ready)) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (take && !q_cmd.is_read && q_cmd.in_grid) begin
            mem[{q_cmd.plane, q_cmd.row}] <= q_cmd.bits;
        end
        rd_reg <= mem[{np[IDX_W-1:0], nr[IDX_W-1:0]}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            used_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            out_valid_reg <= out_valid_next;
            used_reg <= (st_reg == ST_SCAN) && nvalid;
        end
        if (take) begin
            plane_reg <= q_cmd.plane;
            row_reg <= q_cmd.row;
            step_reg <= 4'd0;
            for (int k = 0; k < ROW_W; k++) cnt_reg[k] <= 5'd0;
            if (q_cmd.is_read && !q_cmd.in_grid) begin
                out_in_reg <= '0;
                out_dr_reg <= '0;
            end
        end else if (st_reg == ST_SCAN) begin
            step_reg <= step_reg + 4'd1;
        end
        self_reg <= (st_reg == ST_SCAN) && (step_reg == 4'd4);
        if (self_reg) self_bits_reg <= row_m;
        if (used_reg) begin
            for (int k = 0; k < ROW_W; k++) begin
                cnt_reg[k] <= cnt_reg[k] + 5'(row_m[k])
                    + ((k > 0) ? 5'(row_m[(k > 0) ? k - 1 : 0]) : 5'd0)
                    + ((k + 1 < EDGE) ? 5'(row_m[(k + 1 < ROW_W) ? k + 1 : k]) : 5'd0);
            end
        end
        if (st_reg == ST_LAST && (!out_valid_reg || m_ready)) begin
            out_in_reg <= self_bits_reg;
            out_dr_reg <= drw;
        end
    end

`ifndef SYNTHESIS
    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !q_ready) else $error("accept while busy");
    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_SCAN) |-> (step_reg <= 4'd8)) else $error("scan too long");
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_LAST && m_ready) |=> out_valid_reg) else $error("lost result");
`endif
endmodule

@@ rtl/voxel_boundary_marker.sv @@
// ----------------------------------------------------------------------------
// voxel_boundary_marker
// Occupancy grid store with 3x3x3 boundary classification of read rows.
// ----------------------------------------------------------------------------
// A write word, and a read word outside the grid, are taken by the back end
// without leaving its idle state. A read word inside the grid holds the back
// end while it is taken, while the nine neighbor rows are fetched one per
// cycle from the single row memory, while the last row reaches the counters
// and while the result is registered. Each word first passes the two-entry
// queue that lets the front accept words while the back end works. A result
// that is held stalls the back end until it is taken.
module voxel_boundary_marker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [1:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [vbm_pkg::IDX_W-1:0] s_plane_index,
    input  logic [vbm_pkg::IDX_W-1:0] s_row_index,
    input  logic [vbm_pkg::ROW_W-1:0] s_row_bits,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [vbm_pkg::ROW_W-1:0] m_in_range_bits,
    output logic [vbm_pkg::ROW_W-1:0] m_drawable_bits
);
    import vbm_pkg::*;

    logic [CNT_W-1:0] thresh_reg;
    logic             q_valid, q_ready;
    vbm_cmd_t         q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESHOLD) ? {27'd0, thresh_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_THRESHOLD) begin
            thresh_reg <= pwdata[CNT_W-1:0];
        end
    end

    vbm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_plane_index,
        .s_row_index, .s_row_bits, .q_valid, .q_ready, .q_cmd
    );

    vbm_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .thresh(thresh_reg),
        .m_valid, .m_ready, .m_in_range_bits, .m_drawable_bits
    );
endmodule
